// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    // Width of keys, values and read data.
    localparam int DATA_W = 32;

    // Width of the capacity register.
    localparam int CAP_W = 5;

    // Default number of entries.
    localparam int ENTRIES_DEFAULT = 16;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Data returned by a get that misses.
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // Request operation codes.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } op_t;

endpackage

// ----- rtl/lkvc_value_mem.sv -----
// Value storage: one write port and one read port with registered read data.
module lkvc_value_mem
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                      wr_data,
    input  logic                                   rd_en,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                      rd_data
);

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lkvc_dir.sv -----
// Directory: keys, valid bits, recency ranks, entry count, lookup and replacement.
module lkvc_dir
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   upd_en,
    input  op_t                                    req_op,
    input  logic [DATA_W-1:0]                      req_key,
    input  logic [CAP_W-1:0]                       capacity,
    output logic                                   hit,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] slot_idx
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;

    logic [DATA_W-1:0] key_reg  [ENTRIES];
    logic [RW-1:0]     rank_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CNTW-1:0]   count_reg;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      victim_idx;
    logic [IW-1:0]      free_idx;
    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    eff_cap;
    logic               full;
    logic               insert_new;
    logic               do_update;
    logic               write_key;
    logic [IW-1:0]      target;
    logic [CNTW-1:0]    threshold;
    logic [CNTW-1:0]    count_minus1;

    // Parallel key compare, oldest-entry match and first free slot.
    always_comb
    begin
        count_minus1 = count_reg - CNTW'(1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (key_reg[i] == req_key);
            victim_vec[i] = valid_reg[i] && (CNTW'(rank_reg[i]) == count_minus1);
        end
        free_vec = ~valid_reg & (valid_reg + ENTRIES'(1));
    end

    // One-hot to index encoders.
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
            if (victim_vec[i])
            begin
                victim_idx = victim_idx | IW'(i);
            end
            if (free_vec[i])
            begin
                free_idx = free_idx | IW'(i);
            end
        end
    end

    // Effective capacity: zero counts as one, values above the depth saturate.
    always_comb
    begin
        cap_ext = CMPW'(capacity);
        if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(ENTRIES))
        begin
            eff_cap = CMPW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = CMPW'(count_reg) >= eff_cap;
    end

    // Choose the entry to touch and the rank below which entries age.
    always_comb
    begin
        hit        = |hit_vec;
        insert_new = !hit && (req_op == OP_SET) && !full;
        write_key  = upd_en && !hit && (req_op == OP_SET);
        do_update  = upd_en && (hit || (req_op == OP_SET));
        if (hit)
        begin
            target    = hit_idx;
            threshold = CNTW'(rank_reg[hit_idx]);
        end
        else if (full)
        begin
            target    = victim_idx;
            threshold = CNTW'(rank_reg[victim_idx]);
        end
        else
        begin
            target    = free_idx;
            threshold = count_reg;
        end
        slot_idx = target;
    end

    // Keys and ranks carry no reset; they are only read behind a valid bit.
    always_ff @(posedge clk)
    begin
        if (write_key)
        begin
            key_reg[target] <= req_key;
        end
        if (do_update)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IW'(i) == target)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (CNTW'(rank_reg[i]) < threshold))
                begin
                    rank_reg[i] <= rank_reg[i] + RW'(1);
                end
            end
        end
    end

    // Valid bits and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (upd_en && insert_new)
        begin
            valid_reg[target] <= 1'b1;
            count_reg         <= count_reg + CNTW'(1);
        end
    end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: request control, result register, assertions.
//
// Requests enter on the in channel (in_valid, in_stall, op, key, value) and are
// taken at a clock edge with in_valid high and in_stall low. A get returns one
// result on the out channel (out_valid, out_stall, read_value, hit); a set
// returns nothing. On a miss read_value is all ones and hit is low.
// The user must write the capacity register through cfg_wr_en and cfg_wr_data only
// while idle; the block itself does not enforce this. A request first passes the
// lookup state: the parallel key compare with the rank update and the write (a set)
// or read (a get) of the value memory. A set then goes back to idle; a get passes
// the response state, in which its result is loaded and the next request can be
// taken. If the receiver stalls, the result stays in the output register and one
// further get finishes its lookup, then waits with in_stall high.
// Reset empties the cache (all valid bits and the entry count clear) and sets
// the capacity to 16; no clearing pass is needed, requests are taken at once.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     hit,
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_RESP
    } state_t;

    state_t            state_reg;
    op_t               req_op_reg;
    logic [DATA_W-1:0] req_key_reg;
    logic [DATA_W-1:0] req_value_reg;
    logic              resp_hit_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_hit_reg;
    logic [CAP_W-1:0]  capacity_reg;

    logic              dir_hit;
    logic [IW-1:0]     dir_slot;
    logic              look;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;
    logic              out_free;
    logic              accept;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Handshake and memory control.
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        in_stall = !((state_reg == S_IDLE) || ((state_reg == S_RESP) && out_free));
        accept   = in_valid && !in_stall;
        look     = (state_reg == S_LOOK);
        mem_we   = look && (req_op_reg == OP_SET);
        mem_re   = look && (req_op_reg == OP_GET) && dir_hit;
    end

    lkvc_dir #(
        .ENTRIES (ENTRIES)
    ) u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (look),
        .req_op   (req_op_reg),
        .req_key  (req_key_reg),
        .capacity (capacity_reg),
        .hit      (dir_hit),
        .slot_idx (dir_slot)
    );

    lkvc_value_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (dir_slot),
        .wr_data (req_value_reg),
        .rd_en   (mem_re),
        .rd_addr (dir_slot),
        .rd_data (mem_rdata)
    );

    // Request sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_op_reg    <= op_t'(op);
                        req_key_reg   <= key;
                        req_value_reg <= value;
                        state_reg     <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    resp_hit_reg <= dir_hit;
                    if (req_op_reg == OP_GET)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= resp_hit_reg ? mem_rdata : MISS_VALUE;
                        out_hit_reg   <= resp_hit_reg;
                        if (accept)
                        begin
                            req_op_reg    <= op_t'(op);
                            req_key_reg   <= key;
                            req_value_reg <= value;
                            state_reg     <= S_LOOK;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign hit        = out_hit_reg;

`ifndef SYNTHESIS
    // The value memory is read only for a get that hit.
    a_read_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (dir_hit && (req_op_reg == OP_GET)))
        else $error("value memory read without a get hit");

    // A miss result always carries the miss value.
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_value_reg == MISS_VALUE))
        else $error("miss result with data other than all ones");

    // Only a get reaches the response state, and only straight from lookup.
    a_resp_is_get: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && !$past(state_reg == S_RESP)) |->
            ((req_op_reg == OP_GET) && $past(state_reg == S_LOOK)))
        else $error("response state entered without a get lookup");
`endif

endmodule
